// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers for the region allocator rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge outside reset
`define VRA_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define VRA_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define VRA_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/vra_pkg.sv =====
// ---------------------------------------------------------------------------
// vra_pkg
// shared constants, types and codes of the virtual region allocator
// ---------------------------------------------------------------------------
package vra_pkg;

   localparam int MAX_REGIONS = 64;
   localparam int PAGE_BYTES  = 4096;

   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int IDX_W      = $clog2(MAX_REGIONS);
   localparam int CNT_W      = $clog2(MAX_REGIONS + 1);
   localparam int ADDR_W     = 32;
   localparam int PAGES_W    = 21;
   localparam int NEED_W     = ADDR_W - PAGE_SHIFT + 1;
   localparam int SUM_W      = ((NEED_W > PAGES_W) ? NEED_W : PAGES_W) + 1;
   localparam int ENTRY_W    = ADDR_W + PAGES_W;

   localparam int NUM_REGS   = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = $clog2(4 * NUM_REGS);
   localparam int REG_SEL_W  = CSR_ADDR_W - 2;

   localparam logic [REG_SEL_W-1:0] REG_POOL_BASE  = REG_SEL_W'(0);
   localparam logic [REG_SEL_W-1:0] REG_POOL_BYTES = REG_SEL_W'(1);

   localparam logic [1:0] OP_ALLOCATE = 2'd0;
   localparam logic [1:0] OP_RELEASE  = 2'd1;
   localparam logic [1:0] OP_CHECK    = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_SPACE   = 2'd1,
      STATUS_TABLE_FULL = 2'd2,
      STATUS_NOT_FOUND  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ALLOC_WR,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] pool_base;
      logic [ADDR_W-1:0] pool_bytes;
   } pool_cfg_type;

endpackage

// ===== rtl/vra_req_if.sv =====
// ---------------------------------------------------------------------------
// vra_req_if
// request channel of the region allocator: operation and its operands
// ---------------------------------------------------------------------------
interface vra_req_if import vra_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        operation;
   logic [ADDR_W-1:0] request_bytes;
   logic [ADDR_W-1:0] target_address;

   modport source (output valid, output operation, output request_bytes,
                   output target_address, input ready);
   modport sink   (input valid, input operation, input request_bytes,
                   input target_address, output ready);
endinterface

// ===== rtl/vra_rsp_if.sv =====
// ---------------------------------------------------------------------------
// vra_rsp_if
// response channel of the region allocator
// ---------------------------------------------------------------------------
interface vra_rsp_if import vra_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [ADDR_W-1:0]  region_address;
   logic [PAGES_W-1:0] page_count;
   logic               is_inside;

   modport source (output valid, output status, output region_address,
                   output page_count, output is_inside, input ready);
   modport sink   (input valid, input status, input region_address,
                   input page_count, input is_inside, output ready);
endinterface

// ===== rtl/virtual_region_allocator.sv =====
// ---------------------------------------------------------------------------
// virtual_region_allocator
// bump pointer region allocator over a virtual pool with a region table
// ---------------------------------------------------------------------------
// One request is worked on at a time; a new request is taken while the
// previous response still waits on the response channel. A check or an
// unused operation goes from the execute state straight to the finish
// state, as does a failed allocate or one on an empty table; any other
// allocate reads the last table entry and then writes the new one. A
// release scans the table and, on a hit, moves the entries above it down
// by one: the table lives in one RAM with a single read port, so the
// search walks it one entry per cycle and the entries above the hit are
// then moved down one per cycle. The table needs no clearing after reset.
`include "assert_macros.svh"

module virtual_region_allocator import vra_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   vra_req_if.sink               req_if,
   vra_rsp_if.source             rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   pool_cfg_type cfg;

   state_type          state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [ADDR_W-1:0]  bytes_ff, bytes_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [NEED_W-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic               pend_ff, pend_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               found_ff, found_in;
   logic [CNT_W-1:0]   hit_ff, hit_in;
   logic [ADDR_W-1:0]  hit_start_ff, hit_start_in;
   logic [PAGES_W-1:0] hit_pages_ff, hit_pages_in;
   status_type         res_status_ff, res_status_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic [PAGES_W-1:0] res_pages_ff, res_pages_in;
   logic               res_inside_ff, res_inside_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [PAGES_W-1:0] rsp_pages_ff, rsp_pages_in;
   logic               rsp_inside_ff, rsp_inside_in;

   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   logic [ENTRY_W-1:0] mem_wr_data;
   logic               mem_rd_en;
   logic [IDX_W-1:0]   mem_rd_addr;
   logic [ENTRY_W-1:0] mem_rd_data;
   logic [ADDR_W-1:0]  rd_start;
   logic [PAGES_W-1:0] rd_pages;

   logic                accept;
   logic [ADDR_W:0]     bytes_round;
   logic [NEED_W-1:0]   need;
   logic [NEED_W-2:0]   capacity;
   logic                no_space;
   logic                table_full;
   logic                addr_in_pool;
   logic [ADDR_W-1:0]   tail_start;
   logic [ADDR_W-1:0]   first_start;
   logic                issue;
   logic                match;
   logic                scan_done;
   logic                shift_done;
   logic [SUM_W-1:0]    used_ext;
   logic [SUM_W-1:0]    free_ext;
   logic [NEED_W-1:0]   used_after_release;
   logic                out_free;

   vra_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   vra_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_REGIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rd_start = mem_rd_data[ENTRY_W-1:PAGES_W];
   assign rd_pages = mem_rd_data[PAGES_W-1:0];

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;

   // page rounding and capacity test
   assign bytes_round = {1'b0, bytes_ff} + (ADDR_W + 1)'(PAGE_BYTES - 1);
   assign need        = bytes_round[ADDR_W:PAGE_SHIFT];
   assign capacity    = cfg.pool_bytes[ADDR_W-1:PAGE_SHIFT];
   assign no_space    = (SUM_W'(used_ff) + SUM_W'(need)) > SUM_W'(capacity);
   assign table_full  = (count_ff == CNT_W'(MAX_REGIONS));

   assign addr_in_pool = (addr_ff >= cfg.pool_base) &&
                   ({1'b0, addr_ff} <= ({1'b0, cfg.pool_base} + {1'b0, cfg.pool_bytes}));

   assign first_start = cfg.pool_base + ADDR_W'(PAGE_BYTES);
   assign tail_start  = rd_start + ADDR_W'({{ADDR_W{1'b0}}, rd_pages} << PAGE_SHIFT);

   assign issue      = (ptr_ff < count_ff);
   assign match      = pend_ff && (rd_start == addr_ff);
   assign scan_done  = pend_ff && (rd_idx_ff == (count_ff - CNT_W'(1)));
   assign shift_done = !issue && !pend_ff;

   assign used_ext           = SUM_W'(used_ff);
   assign free_ext           = SUM_W'(hit_pages_ff);
   assign used_after_release = (used_ext > free_ext) ? NEED_W'(used_ext - free_ext) : '0;

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (op_ff)
               OP_ALLOCATE: begin
                  if (!no_space && !table_full && (count_ff != '0)) begin
                     state_in = ST_ALLOC_WR;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               OP_RELEASE: begin
                  state_in = (count_ff == '0) ? ST_FINISH : ST_SCAN;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_ALLOC_WR: state_in = ST_FINISH;
         ST_SCAN: begin
            if (scan_done) state_in = (found_ff || match) ? ST_SHIFT : ST_FINISH;
         end
         ST_SHIFT: begin
            if (shift_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and table control
   always_comb begin
      op_in         = op_ff;
      bytes_in      = bytes_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      ptr_in        = ptr_ff;
      pend_in       = 1'b0;
      rd_idx_in     = rd_idx_ff;
      found_in      = found_ff;
      hit_in        = hit_ff;
      hit_start_in  = hit_start_ff;
      hit_pages_in  = hit_pages_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_pages_in  = res_pages_ff;
      res_inside_in = res_inside_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_pages_in  = rsp_pages_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_valid_in  = rsp_if.ready ? 1'b0 : rsp_valid_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = IDX_W'(count_ff);
      mem_wr_data   = {first_start, PAGES_W'(need)};
      mem_rd_en     = 1'b0;
      mem_rd_addr   = IDX_W'(ptr_ff);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_if.operation;
               bytes_in = req_if.request_bytes;
               addr_in  = req_if.target_address;
            end
         end
         ST_EXEC: begin
            res_status_in = STATUS_OK;
            res_addr_in   = '0;
            res_pages_in  = '0;
            res_inside_in = 1'b0;
            ptr_in        = '0;
            found_in      = 1'b0;
            case (op_ff)
               OP_ALLOCATE: begin
                  if (no_space) begin
                     res_status_in = STATUS_NO_SPACE;
                  end else if (table_full) begin
                     res_status_in = STATUS_TABLE_FULL;
                  end else if (count_ff == '0) begin
                     mem_wr_en    = 1'b1;
                     count_in     = count_ff + CNT_W'(1);
                     used_in      = used_ff + need;
                     res_addr_in  = first_start;
                     res_pages_in = PAGES_W'(need);
                  end else begin
                     // fetch the last entry to find the end of the table
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = IDX_W'(count_ff - CNT_W'(1));
                  end
               end
               OP_RELEASE: begin
                  if (count_ff == '0) res_status_in = STATUS_NOT_FOUND;
               end
               OP_CHECK: res_inside_in = addr_in_pool;
               default: ;
            endcase
         end
         ST_ALLOC_WR: begin
            mem_wr_en    = 1'b1;
            mem_wr_data  = {tail_start, PAGES_W'(need)};
            count_in     = count_ff + CNT_W'(1);
            used_in      = used_ff + need;
            res_addr_in  = tail_start;
            res_pages_in = PAGES_W'(need);
         end
         ST_SCAN: begin
            if (issue) begin
               mem_rd_en = 1'b1;
               ptr_in    = ptr_ff + CNT_W'(1);
               pend_in   = 1'b1;
               rd_idx_in = ptr_ff;
            end
            // later matches win, so the last matching entry is kept
            if (match) begin
               found_in     = 1'b1;
               hit_in       = rd_idx_ff;
               hit_start_in = rd_start;
               hit_pages_in = rd_pages;
            end
            if (scan_done) begin
               pend_in = 1'b0;
               if (found_ff || match) begin
                  ptr_in = (match ? rd_idx_ff : hit_ff) + CNT_W'(1);
               end else begin
                  res_status_in = STATUS_NOT_FOUND;
               end
            end
         end
         ST_SHIFT: begin
            if (issue) begin
               mem_rd_en = 1'b1;
               ptr_in    = ptr_ff + CNT_W'(1);
               pend_in   = 1'b1;
               rd_idx_in = ptr_ff;
            end
            // entry read last cycle moves down by one
            if (pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = IDX_W'(rd_idx_ff - CNT_W'(1));
               mem_wr_data = mem_rd_data;
            end
            if (shift_done) begin
               count_in      = count_ff - CNT_W'(1);
               used_in       = used_after_release;
               res_status_in = STATUS_OK;
               res_addr_in   = hit_start_ff;
               res_pages_in  = hit_pages_ff;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_pages_in  = res_pages_ff;
               rsp_inside_in = res_inside_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         used_ff      <= NEED_W'(1);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      bytes_ff      <= bytes_in;
      addr_ff       <= addr_in;
      ptr_ff        <= ptr_in;
      rd_idx_ff     <= rd_idx_in;
      found_ff      <= found_in;
      hit_ff        <= hit_in;
      hit_start_ff  <= hit_start_in;
      hit_pages_ff  <= hit_pages_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_pages_ff  <= res_pages_in;
      res_inside_ff <= res_inside_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_pages_ff  <= rsp_pages_in;
      rsp_inside_ff <= rsp_inside_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = rsp_status_ff;
   assign rsp_if.region_address = rsp_addr_ff;
   assign rsp_if.page_count     = rsp_pages_ff;
   assign rsp_if.is_inside      = rsp_inside_ff;

   `VRA_ASSERT(a_count_range, count_ff <= CNT_W'(MAX_REGIONS), "region count above table depth")
   `VRA_ASSERT(a_used_nonzero, used_ff != '0, "table page no longer counted as used")
   `VRA_IMPLY(a_rsp_from_finish, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH,
              "response raised outside finish")
   `VRA_IMPLY(a_shift_in_table, (state_ff == ST_SHIFT) && pend_ff,
              (rd_idx_ff != '0) && (rd_idx_ff < count_ff), "shift write outside table")
   `VRA_NEXT(a_release_shrinks, (state_ff == ST_SHIFT) && shift_done,
             count_ff == ($past(count_ff) - CNT_W'(1)), "release did not drop one region")

endmodule

// ===== rtl/vra_ram.sv =====
// ---------------------------------------------------------------------------
// vra_ram
// generic simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module vra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/vra_csr.sv =====
// ---------------------------------------------------------------------------
// vra_csr
// apb register file holding the pool base and pool size
// ---------------------------------------------------------------------------
module vra_csr import vra_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output pool_cfg_type          cfg
);

   logic [ADDR_W-1:0]    pool_base_ff, pool_base_in;
   logic [ADDR_W-1:0]    pool_bytes_ff, pool_bytes_in;
   logic                 wr_en;
   logic [REG_SEL_W-1:0] reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      pool_base_in  = pool_base_ff;
      pool_bytes_in = pool_bytes_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_POOL_BASE:  pool_base_in  = pwdata;
            REG_POOL_BYTES: pool_bytes_in = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_POOL_BASE:  prdata = pool_base_ff;
         REG_POOL_BYTES: prdata = pool_bytes_ff;
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff  <= '0;
         pool_bytes_ff <= '0;
      end else begin
         pool_base_ff  <= pool_base_in;
         pool_bytes_ff <= pool_bytes_in;
      end
   end

   assign cfg.pool_base  = pool_base_ff;
   assign cfg.pool_bytes = pool_bytes_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the virtual region allocator
// ---------------------------------------------------------------------------
// Requests are queued phase by phase and go out in random bursts, but back
// to back in one phase. Each accepted request runs through a predictor that
// keeps its own region table. Responses come back under a stall pattern
// and are checked field by field, in order. The pool registers are
// rewritten between phases, with the extreme settings among them.
module tb_top;
   import vra_pkg::*;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_REQUESTS = 142;
   localparam int DRAIN_CYCLES   = 4 * MAX_REGIONS + 16;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      TARGET_FIXED,
      TARGET_LIVE,
      TARGET_NEAR_LIVE
   } target_kind_type;

   typedef struct {
      logic [1:0]        operation;
      logic [ADDR_W-1:0] request_bytes;
      logic [ADDR_W-1:0] target_address;
      target_kind_type   target_kind;
   } request_type;

   typedef struct {
      status_type         status;
      logic [ADDR_W-1:0]  region_address;
      logic [PAGES_W-1:0] page_count;
      logic               is_inside;
   } response_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   vra_req_if req_if ();
   vra_rsp_if rsp_if ();

   virtual_region_allocator u_top (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor copy of the pool registers and the region table
   logic [ADDR_W-1:0]  pool_base_cfg = '0;
   logic [ADDR_W-1:0]  pool_bytes_cfg = '0;
   logic [ADDR_W-1:0]  region_starts [MAX_REGIONS];
   logic [PAGES_W-1:0] region_pages [MAX_REGIONS];
   int                 region_total = 0;
   longint unsigned    pages_in_use = 1;

   request_type  pending_requests [$];
   response_type expected_responses [$];
   int           queued_requests = 0;
   int           accepted_requests = 0;
   int           error_count = 0;
   int           cycle_count = 0;

   logic         request_taken = 1'b0;
   int           burst_left = 0;
   int           gap_left = 0;
   bit           steady_sender = 1'b0;
   logic [15:0]  stall_shape = '1;
   logic [3:0]   stall_phase = '0;

   function automatic void report_mismatch(string text);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("mismatch: %s", text);
   endfunction

   function automatic response_type predict_response(logic [1:0] operation,
         logic [ADDR_W-1:0] request_bytes, logic [ADDR_W-1:0] target_address);
      response_type    rs;
      longint unsigned bytes_wide;
      longint unsigned base_wide;
      longint unsigned size_wide;
      longint unsigned target_wide;
      longint unsigned need_pages;
      int              hit;
      int              i;
      rs.status         = STATUS_OK;
      rs.region_address = '0;
      rs.page_count     = '0;
      rs.is_inside      = 1'b0;
      bytes_wide  = request_bytes;
      base_wide   = pool_base_cfg;
      size_wide   = pool_bytes_cfg;
      target_wide = target_address;
      case (operation)
         OP_ALLOCATE: begin
            need_pages = (bytes_wide + PAGE_BYTES - 1) / PAGE_BYTES;
            // space is tested ahead of table room
            if (pages_in_use + need_pages > size_wide / PAGE_BYTES) begin
               rs.status = STATUS_NO_SPACE;
            end else if (region_total >= MAX_REGIONS) begin
               rs.status = STATUS_TABLE_FULL;
            end else begin
               if (region_total == 0)
                  rs.region_address = pool_base_cfg + ADDR_W'(PAGE_BYTES);
               else
                  rs.region_address = region_starts[region_total - 1] +
                     ADDR_W'(region_pages[region_total - 1]) * ADDR_W'(PAGE_BYTES);
               rs.page_count = PAGES_W'(need_pages);
               region_starts[region_total] = rs.region_address;
               region_pages[region_total]  = rs.page_count;
               region_total++;
               pages_in_use += need_pages;
            end
         end
         OP_RELEASE: begin
            hit = -1;
            for (i = 0; i < region_total; i++)
               if (region_starts[i] == target_address)
                  hit = i;
            if (hit < 0) begin
               rs.status = STATUS_NOT_FOUND;
            end else begin
               rs.region_address = region_starts[hit];
               rs.page_count     = region_pages[hit];
               for (i = hit; i + 1 < region_total; i++) begin
                  region_starts[i] = region_starts[i + 1];
                  region_pages[i]  = region_pages[i + 1];
               end
               region_total--;
               pages_in_use = (pages_in_use > rs.page_count) ?
                              pages_in_use - rs.page_count : 0;
            end
         end
         OP_CHECK: begin
            // upper bound does not wrap
            rs.is_inside = (target_wide >= base_wide) &&
                           (target_wide <= base_wide + size_wide);
         end
         default: ;
      endcase
      return rs;
   endfunction

   // live targets are picked when the request goes out, from the table as it
   // stands then; only one request is ever between driver and predictor
   function automatic logic [ADDR_W-1:0] resolve_target(request_type rq);
      logic [ADDR_W-1:0] live;
      if (rq.target_kind == TARGET_FIXED || region_total == 0)
         return rq.target_address;
      live = region_starts[$urandom_range(region_total - 1)];
      if (rq.target_kind == TARGET_LIVE)
         return live;
      return live + rq.target_address;
   endfunction

   function automatic logic [ADDR_W-1:0] random_size();
      case ($urandom_range(7))
         0:       return '0;
         1:       return PAGE_BYTES * $urandom_range(1, 16);
         2:       return PAGE_BYTES * $urandom_range(1, 16) + 1;
         3:       return PAGE_BYTES * $urandom_range(1, 16) - 1;
         4:       return $urandom;
         default: return $urandom_range(4 * PAGE_BYTES);
      endcase
   endfunction

   task automatic queue_request(logic [1:0] operation, logic [ADDR_W-1:0] request_bytes,
         logic [ADDR_W-1:0] target_address, target_kind_type target_kind);
      request_type rq;
      rq.operation      = operation;
      rq.request_bytes  = request_bytes;
      rq.target_address = target_address;
      rq.target_kind    = target_kind;
      pending_requests.push_back(rq);
      queued_requests++;
   endtask

   task automatic queue_random_requests(int count, int alloc_weight, bit tiny_sizes);
      int                pick;
      logic [ADDR_W-1:0] size;
      logic [ADDR_W-1:0] where;
      target_kind_type   kind;
      repeat (count) begin
         pick = $urandom_range(99);
         kind = TARGET_FIXED;
         where = $urandom;
         if (pick < alloc_weight) begin
            size = tiny_sizes ? $urandom_range(PAGE_BYTES) : random_size();
            queue_request(OP_ALLOCATE, size, where, kind);
         end else if (pick < alloc_weight + (100 - alloc_weight) / 2) begin
            case ($urandom_range(9))
               0: kind = TARGET_FIXED;
               1: begin
                  kind = TARGET_NEAR_LIVE;
                  case ($urandom_range(2))
                     0:       where = 1;
                     1:       where = '1;
                     default: where = PAGE_BYTES;
                  endcase
               end
               default: kind = TARGET_LIVE;
            endcase
            queue_request(OP_RELEASE, $urandom, where, kind);
         end else if (pick < 97) begin
            case ($urandom_range(5))
               0: where = pool_base_cfg;
               1: where = pool_base_cfg - 1;
               2: where = pool_base_cfg + pool_bytes_cfg;
               3: where = pool_base_cfg + pool_bytes_cfg + 1;
               default: ;
            endcase
            queue_request(OP_CHECK, $urandom, where, kind);
         end else begin
            queue_request(OP_UNUSED, $urandom, where, kind);
         end
      end
   endtask

   task automatic queue_table_flush();
      repeat (region_total) queue_request(OP_RELEASE, '0, '0, TARGET_LIVE);
   endtask

   task automatic wait_drained();
      while (accepted_requests != queued_requests || expected_responses.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_access(logic [REG_SEL_W-1:0] index, bit is_write,
         logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (!is_write && prdata !== value)
         report_mismatch($sformatf("register %0d read %h, expected %h",
                                   index, prdata, value));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic configure_pool(logic [ADDR_W-1:0] base_value,
         logic [ADDR_W-1:0] bytes_value);
      csr_access(REG_POOL_BASE, 1'b1, base_value);
      pool_base_cfg = base_value;
      csr_access(REG_POOL_BYTES, 1'b1, bytes_value);
      pool_bytes_cfg = bytes_value;
      csr_access(REG_POOL_BASE, 1'b0, base_value);
      csr_access(REG_POOL_BYTES, 1'b0, bytes_value);
   endtask

   // request driver and response ready pattern
   always @(negedge clock) begin
      request_type rq;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || request_taken) begin
         if (gap_left > 0) begin
            req_if.valid <= 1'b0;
            gap_left--;
         end else if (pending_requests.size() > 0) begin
            rq = pending_requests.pop_front();
            req_if.operation      <= rq.operation;
            req_if.request_bytes  <= rq.request_bytes;
            req_if.target_address <= resolve_target(rq);
            req_if.valid          <= 1'b1;
            if (burst_left > 0)
               burst_left--;
            if (burst_left == 0 && !steady_sender) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = $urandom_range(0, 10);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
      rsp_if.ready <= reset ? 1'b0 : stall_shape[stall_phase];
      stall_phase  <= stall_phase + 4'd1;
   end

   // monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      response_type want;
      if (reset) begin
         request_taken <= 1'b0;
      end else begin
         request_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_responses.size() == 0) begin
               report_mismatch($sformatf("unexpected response status %0d addr %h pages %0d inside %b",
                  rsp_if.status, rsp_if.region_address, rsp_if.page_count, rsp_if.is_inside));
            end else begin
               want = expected_responses.pop_front();
               if (rsp_if.status !== want.status ||
                   rsp_if.region_address !== want.region_address ||
                   rsp_if.page_count !== want.page_count ||
                   rsp_if.is_inside !== want.is_inside)
                  report_mismatch($sformatf(
                     "expected status %0d addr %h pages %0d inside %b, got %0d %h %0d %b",
                     want.status, want.region_address, want.page_count, want.is_inside,
                     rsp_if.status, rsp_if.region_address, rsp_if.page_count,
                     rsp_if.is_inside));
            end
         end
         if (req_if.valid && req_if.ready) begin
            expected_responses.push_back(predict_response(req_if.operation,
               req_if.request_bytes, req_if.target_address));
            accepted_requests++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("virtual_region_allocator test failed");
         $finish;
      end
   end

   initial begin
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] size;
      int                alloc_weight;
      bit                tiny_sizes;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      req_if.valid          = 1'b0;
      req_if.operation      = OP_ALLOCATE;
      req_if.request_bytes  = '0;
      req_if.target_address = '0;
      rsp_if.ready          = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // empty pool straight out of reset
      queue_request(OP_ALLOCATE, '0, '0, TARGET_FIXED);
      queue_request(OP_CHECK, '0, '0, TARGET_FIXED);
      queue_request(OP_CHECK, '0, 1, TARGET_FIXED);
      wait_drained();

      // sixteen page pool, hand-made sequence
      base = 32'h1000_0000;
      configure_pool(base, 16 * PAGE_BYTES);
      queue_request(OP_ALLOCATE, '0, '0, TARGET_FIXED);
      queue_request(OP_ALLOCATE, 1, '0, TARGET_FIXED);
      queue_request(OP_ALLOCATE, PAGE_BYTES, '0, TARGET_FIXED);
      queue_request(OP_ALLOCATE, PAGE_BYTES + 1, '0, TARGET_FIXED);
      queue_request(OP_ALLOCATE, '1, '0, TARGET_FIXED);
      // two entries share a start: the later one goes first
      queue_request(OP_RELEASE, '0, base + PAGE_BYTES, TARGET_FIXED);
      queue_request(OP_RELEASE, '0, base + PAGE_BYTES, TARGET_FIXED);
      queue_request(OP_RELEASE, '0, base + PAGE_BYTES, TARGET_FIXED);
      queue_request(OP_RELEASE, '0, base, TARGET_FIXED);
      queue_request(OP_RELEASE, '1, '1, TARGET_FIXED);
      queue_request(OP_RELEASE, '0, base + 2 * PAGE_BYTES, TARGET_FIXED);
      queue_request(OP_ALLOCATE, 13 * PAGE_BYTES, '0, TARGET_FIXED);
      queue_request(OP_ALLOCATE, 1, '0, TARGET_FIXED);
      queue_request(OP_ALLOCATE, '0, '0, TARGET_FIXED);
      queue_request(OP_CHECK, '0, base - 1, TARGET_FIXED);
      queue_request(OP_CHECK, '0, base, TARGET_FIXED);
      queue_request(OP_CHECK, '0, base + 16 * PAGE_BYTES, TARGET_FIXED);
      queue_request(OP_CHECK, '0, base + 16 * PAGE_BYTES + 1, TARGET_FIXED);
      queue_request(OP_CHECK, '1, '0, TARGET_FIXED);
      queue_request(OP_CHECK, '0, '1, TARGET_FIXED);
      queue_request(OP_UNUSED, '1, '1, TARGET_FIXED);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         alloc_weight = 45;
         tiny_sizes   = 1'b0;
         base         = $urandom;
         size         = $urandom;
         case (phase)
            0: begin
               base = '0;
               size = '0;
            end
            1: begin
               base = '1;
               size = '1;
            end
            2: begin
               // empty table so the first region lands past the top and wraps
               queue_table_flush();
               wait_drained();
               base = 32'hFFFF_F000;
               size = '1;
               alloc_weight = 50;
            end
            3: begin
               base = base & ~ADDR_W'(PAGE_BYTES - 1);
               size = 8 * PAGE_BYTES + $urandom_range(PAGE_BYTES);
               alloc_weight = 50;
            end
            4: begin
               // many small regions to run the table full
               queue_table_flush();
               wait_drained();
               size = 32'h0100_0000;
               alloc_weight = 85;
               tiny_sizes = 1'b1;
            end
            default: begin
               if ($urandom_range(1))
                  base = base & ~ADDR_W'(PAGE_BYTES - 1);
            end
         endcase
         configure_pool(base, size);
         steady_sender = (phase == 5);
         if (phase == 2 || phase == 5)
            stall_shape = '1;
         else if (phase % 2 == 0)
            stall_shape = 16'($urandom) | 16'h0001;
         else
            stall_shape = 16'($urandom & $urandom) | 16'h0001;
         queue_random_requests(PHASE_REQUESTS, alloc_weight, tiny_sizes);
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      error_count += expected_responses.size();
      if (error_count == 0)
         $display("virtual_region_allocator test passed");
      else
         $display("virtual_region_allocator test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/vra_pkg.sv
rtl/vra_req_if.sv
rtl/vra_rsp_if.sv
rtl/vra_ram.sv
rtl/vra_csr.sv
rtl/virtual_region_allocator.sv
tb/sv/tb_top.sv
